[hdl/lcdseq_pkg.sv]
// Shared types, codes and the power-up table for the LCD nibble write sequencer.
package lcdseq_pkg;

  localparam int HOLD_W = 15;
  localparam int NIB_W  = 4;

  // Display action codes.
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_CURSOR = 2'd2;
  localparam logic [1:0] ACT_INIT   = 2'd3;

  // Pin step within one nibble transfer.
  localparam logic [1:0] STEP_STROBE = 2'd0;
  localparam logic [1:0] STEP_DRIVE  = 2'd1;
  localparam logic [1:0] STEP_SETTLE = 2'd2;

  localparam int INIT_NIBBLES = 16;
  localparam int BYTE_NIBBLES = 2;

  localparam logic [HOLD_W-1:0] STROBE_HOLD = 15'd1;
  localparam logic [HOLD_W-1:0] DRIVE_HOLD  = 15'd0;
  localparam logic [HOLD_W-1:0] BASE_HOLD   = 15'd100;
  localparam logic [HOLD_W-1:0] CLEAR_HOLD  = 15'd1600;

  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic       CURSOR_FLAG = 1'b1;

  typedef struct packed {
    logic             load;
    logic             emit;
    logic [1:0]       step;
    logic [NIB_W-1:0] nib;
    logic             last;
  } lcdseq_cmd_t;

  typedef struct packed {
    logic out_free;
  } lcdseq_sts_t;

  typedef struct packed {
    logic [3:0]        nibble;
    logic [HOLD_W-1:0] settle_hold;
  } init_entry_t;

  // Power-up sequence, one entry per nibble, with the settle hold that follows it.
  function automatic init_entry_t init_entry(input logic [NIB_W-1:0] idx);
    init_entry_t e;
    unique case (idx)
      4'd0:    e = '{4'h0, BASE_HOLD};
      4'd1:    e = '{4'h1, 15'd15100};
      4'd2:    e = '{4'h3, 15'd4600};
      4'd3:    e = '{4'h3, 15'd4600};
      4'd4:    e = '{4'h3, 15'd250};
      4'd5:    e = '{4'h2, 15'd5100};
      4'd6:    e = '{4'h0, BASE_HOLD};
      4'd7:    e = '{4'h1, CLEAR_HOLD};
      4'd8:    e = '{4'h2, BASE_HOLD};
      4'd9:    e = '{4'h8, 15'd5100};
      4'd10:   e = '{4'h0, BASE_HOLD};
      4'd11:   e = '{4'hC, 15'd5100};
      4'd12:   e = '{4'h0, BASE_HOLD};
      4'd13:   e = '{4'h1, 15'd20100};
      4'd14:   e = '{4'h0, BASE_HOLD};
      default: e = '{4'h1, 15'd2100};
    endcase
    return e;
  endfunction

endpackage

[hdl/lcdseq_ctrl.sv]
// Controller: walks the nibbles and pin steps of one display action.
module lcdseq_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               action,
  input  lcdseq_pkg::lcdseq_sts_t  sts,
  output lcdseq_pkg::lcdseq_cmd_t  cmd
);
  import lcdseq_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t           state;
  logic [1:0]       step;
  logic [NIB_W-1:0] nib;
  logic [NIB_W-1:0] nib_end;

  always_comb begin
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.emit = (state == S_RUN) && sts.out_free;
    cmd.step = step;
    cmd.nib  = nib;
    cmd.last = (step == STEP_SETTLE) && (nib == nib_end);
    in_stall = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      step    <= STEP_STROBE;
      nib     <= '0;
      nib_end <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state   <= S_RUN;
            step    <= STEP_STROBE;
            nib     <= '0;
            nib_end <= (action == ACT_INIT) ? NIB_W'(INIT_NIBBLES - 1)
                                            : NIB_W'(BYTE_NIBBLES - 1);
          end
        end
        S_RUN: begin
          if (cmd.emit) begin
            if (cmd.last) begin
              state <= S_IDLE;
            end else if (step == STEP_SETTLE) begin
              step <= STEP_STROBE;
              nib  <= nib + NIB_W'(1);
            end else begin
              step <= step + 2'd1;
            end
          end
        end
      endcase
    end
  end

endmodule

[hdl/lcdseq_dp.sv]
// Datapath: holds the action's byte, forms each pin step and keeps the output register.
module lcdseq_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  lcdseq_pkg::lcdseq_cmd_t  cmd,
  output lcdseq_pkg::lcdseq_sts_t  sts,
  input  logic [1:0]               action,
  input  logic [7:0]               byte_value,
  input  logic                     register_select_in,
  input  logic [5:0]               column,
  input  logic                     row,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [3:0]               data_nibble,
  output logic                     enable,
  output logic                     register_select,
  output logic [lcdseq_pkg::HOLD_W-1:0] hold_us,
  output logic                     last
);
  import lcdseq_pkg::*;

  logic [7:0]        cmd_byte;
  logic              cmd_rs;
  logic [HOLD_W-1:0] byte_hold;
  logic              init_mode;

  logic [6:0]        cursor_addr;
  logic [7:0]        byte_sel;
  init_entry_t       init_cur;
  logic [3:0]        nib_cur;
  logic [HOLD_W-1:0] settle_cur;
  logic [3:0]        data_step;
  logic [HOLD_W-1:0] hold_step;

  always_comb begin
    cursor_addr = {row, 6'b0} + {1'b0, column};
    unique case (action)
      ACT_WRITE:  byte_sel = byte_value;
      ACT_CURSOR: byte_sel = {CURSOR_FLAG, cursor_addr};
      default:    byte_sel = CMD_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_byte  <= byte_sel;
      cmd_rs    <= (action == ACT_WRITE) ? register_select_in : 1'b0;
      byte_hold <= (action == ACT_CLEAR) ? CLEAR_HOLD : BASE_HOLD;
      init_mode <= (action == ACT_INIT);
    end
  end

  // A byte goes out high nibble first; only the low nibble carries the extra delay.
  always_comb begin
    init_cur = init_entry(cmd.nib);
    if (init_mode) begin
      nib_cur    = init_cur.nibble;
      settle_cur = init_cur.settle_hold;
    end else if (cmd.nib[0]) begin
      nib_cur    = cmd_byte[3:0];
      settle_cur = byte_hold;
    end else begin
      nib_cur    = cmd_byte[7:4];
      settle_cur = BASE_HOLD;
    end
    data_step = (cmd.step == STEP_STROBE) ? 4'h0 : nib_cur;
    unique case (cmd.step)
      STEP_STROBE: hold_step = STROBE_HOLD;
      STEP_DRIVE:  hold_step = DRIVE_HOLD;
      default:     hold_step = settle_cur;
    endcase
  end

  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      data_nibble     <= data_step;
      enable          <= (cmd.step != STEP_SETTLE);
      register_select <= cmd_rs;
      hold_us         <= hold_step;
      last            <= cmd.last;
    end
  end

endmodule

[hdl/char_lcd_nibble_write_sequencer_core.sv]
// Top level of the 4-bit character LCD write sequencer.
// Each accepted word is one display action (write byte, clear, set cursor or
// power-up), answered by a run of pin-step words: 6 for a byte action and 48
// for power-up. One step word leaves per cycle while out_stall is low.
// hold_us is the time the downstream timer must keep each pin state. A new
// action is taken as soon as the last step of the previous one sits in the
// output register.
module char_lcd_nibble_write_sequencer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic [7:0]                    byte_value,
  input  logic                          register_select_in,
  input  logic [5:0]                    column,
  input  logic                          row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [3:0]                    data_nibble,
  output logic                          enable,
  output logic                          register_select,
  output logic [lcdseq_pkg::HOLD_W-1:0] hold_us,
  output logic                          last
);
  import lcdseq_pkg::*;

  lcdseq_cmd_t cmd;
  lcdseq_sts_t sts;

  lcdseq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcdseq_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .action             (action),
    .byte_value         (byte_value),
    .register_select_in (register_select_in),
    .column             (column),
    .row                (row),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .data_nibble        (data_nibble),
    .enable             (enable),
    .register_select    (register_select),
    .hold_us            (hold_us),
    .last               (last)
  );

endmodule

[hdl/lcdseq_checker.sv]
// Port-level checks for the LCD write sequencer and their binding to the top level.
module lcdseq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [3:0]                    data_nibble,
  input logic                          enable,
  input logic [lcdseq_pkg::HOLD_W-1:0] hold_us
  ,input logic                         last
);
  import lcdseq_pkg::*;

  // A step word waiting on the consumer keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_nibble) && $stable(hold_us)
                               && $stable(enable) && $stable(last))
    else $error("stalled step word changed");

  // Once a word is taken the block is busy emitting its steps.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("action accepted without going busy");

  // Steps with enable high are short strobes; enable low carries at least the base hold.
  a_strobe_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && enable |-> hold_us <= STROBE_HOLD)
    else $error("strobe step with long hold");

  a_settle_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !enable |-> hold_us >= BASE_HOLD)
    else $error("settle step below base hold");

  // Every action ends on a settle step.
  a_last_settle: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> !enable)
    else $error("last step is not a settle step");

endmodule

bind char_lcd_nibble_write_sequencer_core lcdseq_checker u_lcdseq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .data_nibble (data_nibble),
  .enable      (enable),
  .hold_us     (hold_us),
  .last        (last)
);

[verif/char_lcd_nibble_write_sequencer_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the 4-bit character LCD nibble write sequencer.
module char_lcd_nibble_write_sequencer_core_tb;
  import lcdseq_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_WORDS  = 165;

  typedef struct packed {
    logic [NIB_W-1:0]  nib;
    logic              en;
    logic              rs;
    logic [HOLD_W-1:0] hold;
    logic              fin;
  } pin_step_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        action = ACT_WRITE;
  logic [7:0]        byte_value = 8'h00;
  logic              register_select_in = 1'b0;
  logic [5:0]        column = 6'd0;
  logic              row = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [3:0]        data_nibble;
  logic              enable;
  logic              register_select;
  logic [HOLD_W-1:0] hold_us;
  logic              last;

  pin_step_t pin_steps_due[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        error_count = 0;
  int        words_sent = 0;
  int        steps_checked = 0;
  int        action_count[4] = '{0, 0, 0, 0};
  int        cycle_count = 0;

  char_lcd_nibble_write_sequencer_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .byte_value(byte_value),
    .register_select_in(register_select_in),
    .column(column),
    .row(row),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .data_nibble(data_nibble),
    .enable(enable),
    .register_select(register_select),
    .hold_us(hold_us),
    .last(last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d steps still due", cycle_count,
               pin_steps_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] step %0d: %s got %0d, expected %0d", $realtime, steps_checked, what,
             got, want);
    error_count++;
  endtask

  // Expected pin steps: each nibble is strobe, drive, then settle with its hold.
  task automatic queue_nibble(input logic [3:0] nib, input logic rs,
                              input int extra, input logic fin);
    pin_steps_due.push_back('{4'h0, 1'b1, rs, HOLD_W'(1), 1'b0});
    pin_steps_due.push_back('{nib, 1'b1, rs, HOLD_W'(0), 1'b0});
    pin_steps_due.push_back('{nib, 1'b0, rs, HOLD_W'(100 + extra), fin});
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic rs, input int extra,
                            input logic fin);
    queue_nibble(b[7:4], rs, 0, 1'b0);
    queue_nibble(b[3:0], rs, extra, fin);
  endtask

  task automatic predict_pin_steps(input logic [1:0] act, input logic [7:0] b,
                                   input logic rs, input logic [5:0] col, input logic r);
    logic [6:0] addr;
    addr = {r, 6'b0} + {1'b0, col};
    unique case (act)
      ACT_WRITE:  queue_byte(b, rs, 0, 1'b1);
      ACT_CLEAR:  queue_byte(8'h01, 1'b0, 1500, 1'b1);
      ACT_CURSOR: queue_byte({1'b1, addr}, 1'b0, 0, 1'b1);
      ACT_INIT: begin
        queue_byte(8'h01, 1'b0, 15000, 1'b0);
        queue_nibble(4'h3, 1'b0, 4500, 1'b0);
        queue_nibble(4'h3, 1'b0, 4500, 1'b0);
        queue_nibble(4'h3, 1'b0, 150, 1'b0);
        queue_nibble(4'h2, 1'b0, 5000, 1'b0);
        queue_byte(8'h01, 1'b0, 1500, 1'b0);
        queue_byte(8'h28, 1'b0, 5000, 1'b0);
        queue_byte(8'h0C, 1'b0, 5000, 1'b0);
        queue_byte(8'h01, 1'b0, 20000, 1'b0);
        queue_byte(8'h01, 1'b0, 2000, 1'b1);
      end
    endcase
  endtask

  // Sends one action word. valid stays high after acceptance; the next call
  // or a drain decides whether it drops.
  task automatic send_word(input logic [1:0] act, input logic [7:0] b, input logic rs,
                           input logic [5:0] col, input logic r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    predict_pin_steps(act, b, rs, col, r);
    in_valid           <= 1'b1;
    action             <= act;
    byte_value         <= b;
    register_select_in <= rs;
    column             <= col;
    row                <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    action_count[act]++;
  endtask

  task automatic drain_steps();
    in_valid <= 1'b0;
    do @(posedge clk); while (pin_steps_due.size() != 0);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (!rst && out_valid && !out_stall) begin
      if (pin_steps_due.size() == 0) begin
        $display("[%0t] step word with nothing expected", $realtime);
        error_count++;
      end else begin
        pin_step_t want;
        want = pin_steps_due.pop_front();
        if (data_nibble !== want.nib)
          report_mismatch("data_nibble", int'(data_nibble), int'(want.nib));
        if (enable !== want.en) report_mismatch("enable", int'(enable), int'(want.en));
        if (register_select !== want.rs)
          report_mismatch("register_select", int'(register_select), int'(want.rs));
        if (hold_us !== want.hold)
          report_mismatch("hold_us", int'(hold_us), int'(want.hold));
        if (last !== want.fin) report_mismatch("last", int'(last), int'(want.fin));
      end
      steps_checked++;
    end
  end

  task automatic test_write_byte();
    send_word(ACT_WRITE, 8'h00, 1'b0, 6'd63, 1'b1);
    send_word(ACT_WRITE, 8'hFF, 1'b1, 6'd0, 1'b0);
    send_word(ACT_WRITE, 8'hA5, 1'b0, 6'd21, 1'b0);
    send_word(ACT_WRITE, 8'h5A, 1'b1, 6'd42, 1'b1);
  endtask

  task automatic test_clear();
    send_word(ACT_CLEAR, 8'hFF, 1'b1, 6'd63, 1'b1);
    send_word(ACT_CLEAR, 8'h00, 1'b0, 6'd0, 1'b0);
  endtask

  task automatic test_cursor();
    send_word(ACT_CURSOR, 8'hFF, 1'b1, 6'd0, 1'b0);
    send_word(ACT_CURSOR, 8'h00, 1'b0, 6'd39, 1'b1);
    send_word(ACT_CURSOR, 8'h00, 1'b1, 6'd39, 1'b0);
    send_word(ACT_CURSOR, 8'h3C, 1'b0, 6'd0, 1'b1);
    // Columns past 39 are accepted; row offset plus column still fits in seven bits.
    send_word(ACT_CURSOR, 8'h00, 1'b0, 6'd40, 1'b0);
    send_word(ACT_CURSOR, 8'h00, 1'b0, 6'd63, 1'b1);
    send_word(ACT_CURSOR, 8'hC3, 1'b1, 6'd63, 1'b0);
  endtask

  task automatic test_power_up();
    send_word(ACT_INIT, 8'hFF, 1'b1, 6'd63, 1'b1);
    send_word(ACT_INIT, 8'h00, 1'b0, 6'd0, 1'b0);
    send_word(ACT_WRITE, 8'h41, 1'b1, 6'd5, 1'b0);
    drain_steps();
    send_word(ACT_INIT, 8'h12, 1'b0, 6'd7, 1'b1);
  endtask

  task automatic test_random_actions(input int count, input int send_pct, input int recv_pct);
    int          pick;
    logic [1:0]  act;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) act = ACT_WRITE;
      else if (pick < 60) act = ACT_CLEAR;
      else if (pick < 90) act = ACT_CURSOR;
      else act = ACT_INIT;
      send_word(act, 8'($urandom), 1'($urandom), 6'($urandom), 1'($urandom));
      if ($urandom_range(99) == 0) drain_steps();
    end
    drain_steps();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 38;
    recv_idle_pct = 59;
    test_write_byte();
    test_clear();
    test_cursor();
    test_power_up();
    drain_steps();
    test_random_actions(RANDOM_WORDS, 38, 59);
    test_random_actions(RANDOM_WORDS, 59, 38);
    test_random_actions(RANDOM_WORDS, 0, 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d actions (write %0d, clear %0d, cursor %0d, power-up %0d)",
             words_sent, action_count[ACT_WRITE], action_count[ACT_CLEAR],
             action_count[ACT_CURSOR], action_count[ACT_INIT]);
    $display("Checked %0d pin steps under three idle mixes; %0d mismatches",
             steps_checked, error_count);
    if (error_count == 0 && pin_steps_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/lcdseq_pkg.sv
hdl/lcdseq_ctrl.sv
hdl/lcdseq_dp.sv
hdl/char_lcd_nibble_write_sequencer_core.sv
hdl/lcdseq_checker.sv
verif/char_lcd_nibble_write_sequencer_core_tb.sv
